// ===== rtl/srle_pkg.sv =====
`timescale 1ns / 1ps
package srle_pkg;

   localparam int unsigned CsrAddrWidth = 4;
   localparam int unsigned CsrDataWidth = 32;

   typedef enum logic [1:0] {
      REG_IMAGE_WIDTH  = 2'd0,
      REG_IMAGE_HEIGHT = 2'd1,
      REG_DATA_LENGTH  = 2'd2
   } srle_reg_type;

   typedef enum logic [1:0] {
      KIND_PIXEL = 2'd0,
      KIND_DONE  = 2'd1,
      KIND_ERROR = 2'd2
   } srle_kind_type;

   typedef enum logic [5:0] {
      PH_TABLE     = 6'b000001,
      PH_COUNT     = 6'b000010,
      PH_COLOR     = 6'b000100,
      PH_TRANS     = 6'b001000,
      PH_ROW_END   = 6'b010000,
      PH_IMAGE_END = 6'b100000
   } srle_phase_type;

   typedef struct packed {
      logic [15:0] image_width;
      logic [15:0] image_height;
      logic [31:0] data_length;
   } srle_cfg_type;

   typedef struct packed {
      srle_phase_type phase;
      logic [31:0]    byte_position;
      logic [15:0]    column;
      logic [15:0]    row;
      logic [7:0]     run_remaining;
      logic           stopped;
   } srle_state_type;

   typedef struct packed {
      srle_kind_type kind;
      logic [15:0]   pixel_x;
      logic [15:0]   pixel_y;
      logic [7:0]    pixel_color;
   } srle_result_type;

endpackage

// ===== rtl/srle_req_if.sv =====
`timescale 1ns / 1ps
interface srle_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       first_byte;

   modport source (output valid, output data_byte, output first_byte, input ready);
   modport sink (input valid, input data_byte, input first_byte, output ready);
endinterface

// ===== rtl/srle_rsp_if.sv =====
`timescale 1ns / 1ps
interface srle_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  result_kind;
   logic [15:0] pixel_x;
   logic [15:0] pixel_y;
   logic [7:0]  pixel_color;

   modport source (output valid, output result_kind, output pixel_x, output pixel_y,
                   output pixel_color, input ready);
   modport sink (input valid, input result_kind, input pixel_x, input pixel_y,
                 input pixel_color, output ready);
endinterface

// ===== rtl/srle_csr.sv =====
`timescale 1ns / 1ps
module srle_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [srle_pkg::CsrAddrWidth-1:0] paddr,
   input  logic [srle_pkg::CsrDataWidth-1:0] pwdata,
   output logic [srle_pkg::CsrDataWidth-1:0] prdata,
   output logic                              pready,
   output srle_pkg::srle_cfg_type            cfg
);
   import srle_pkg::*;

   srle_cfg_type cfg_ff;
   srle_cfg_type cfg_in;
   logic         write_en;
   srle_reg_type reg_sel;

   assign write_en = psel & penable & pwrite;
   assign reg_sel  = srle_reg_type'(paddr[CsrAddrWidth-1:2]);
   assign pready   = 1'b1;
   assign cfg      = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         unique case (reg_sel)
            REG_IMAGE_WIDTH:  cfg_in.image_width  = pwdata[15:0];
            REG_IMAGE_HEIGHT: cfg_in.image_height = pwdata[15:0];
            REG_DATA_LENGTH:  cfg_in.data_length  = pwdata;
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_IMAGE_WIDTH:  prdata = {16'd0, cfg_ff.image_width};
         REG_IMAGE_HEIGHT: prdata = {16'd0, cfg_ff.image_height};
         REG_DATA_LENGTH:  prdata = cfg_ff.data_length;
         default:          prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end
endmodule

// ===== rtl/srle_decoder.sv =====
`timescale 1ns / 1ps
module srle_decoder (
   input  logic                      clock,
   input  logic                      reset,
   input  srle_pkg::srle_cfg_type    cfg,
   input  logic [7:0]                data_byte,
   input  logic                      first_byte,
   input  logic                      commit,
   output logic                      emit,
   output srle_pkg::srle_result_type result
);
   import srle_pkg::*;

   localparam srle_state_type ClearState = '{
      phase: PH_TABLE, byte_position: 32'd0, column: 16'd0, row: 16'd0,
      run_remaining: 8'd0, stopped: 1'b0};

   srle_state_type state_ff;
   srle_state_type state_in;
   srle_state_type cur;
   srle_phase_type ph;
   logic           table_done;
   logic [32:0]    run_end;
   logic [15:0]    next_column;
   logic [15:0]    next_row;
   logic [7:0]     next_run;

   function automatic srle_phase_type row_start(input logic [15:0] r,
                                                input srle_cfg_type c);
      srle_phase_type p;
      if (r >= c.image_height) begin
         p = PH_IMAGE_END;
      end else if (c.image_width == 16'd0) begin
         p = PH_ROW_END;
      end else begin
         p = PH_COUNT;
      end
      return p;
   endfunction

   always_comb begin
      cur         = first_byte ? ClearState : state_ff;
      state_in    = cur;
      emit        = 1'b0;
      result      = '{kind: KIND_PIXEL, pixel_x: 16'd0, pixel_y: 16'd0, pixel_color: 8'd0};
      ph          = cur.phase;
      table_done  = 1'b1;
      run_end     = {1'b0, cur.byte_position} + {25'd0, data_byte} + 33'd2;
      next_column = cur.column + {8'd0, data_byte};
      next_row    = cur.row + 16'd1;
      next_run    = cur.run_remaining - 8'd1;
      if (!cur.stopped) begin
         if (cfg.data_length == 32'd0) begin
            emit             = 1'b1;
            result.kind      = KIND_DONE;
            state_in.stopped = 1'b1;
         end else if (cur.byte_position >= cfg.data_length) begin
            emit             = 1'b1;
            result.kind      = KIND_ERROR;
            state_in.stopped = 1'b1;
         end else begin
            state_in.byte_position = cur.byte_position + 32'd1;
            if (ph == PH_TABLE) begin
               if ({1'b0, cur.byte_position} < {16'd0, cfg.image_height, 1'b0}) begin
                  table_done = 1'b0;
               end else begin
                  ph = row_start(cur.row, cfg);
               end
            end
            state_in.phase = ph;
            if (table_done) begin
               unique case (ph) inside
                  PH_COUNT: begin
                     if (run_end >= {1'b0, cfg.data_length}) begin
                        emit             = 1'b1;
                        result.kind      = KIND_ERROR;
                        state_in.stopped = 1'b1;
                     end else begin
                        state_in.run_remaining = data_byte;
                        state_in.phase = (data_byte != 8'd0) ? PH_COLOR : PH_TRANS;
                     end
                  end
                  PH_COLOR: begin
                     emit                   = 1'b1;
                     result.pixel_x         = cur.column;
                     result.pixel_y         = cur.row;
                     result.pixel_color     = data_byte;
                     state_in.column        = cur.column + 16'd1;
                     state_in.run_remaining = next_run;
                     if (next_run == 8'd0) begin
                        state_in.phase = PH_TRANS;
                     end
                  end
                  PH_TRANS: begin
                     state_in.column = next_column;
                     state_in.phase  = (next_column < cfg.image_width) ? PH_COUNT : PH_ROW_END;
                  end
                  PH_ROW_END: begin
                     state_in.row    = next_row;
                     state_in.column = 16'd0;
                     state_in.phase  = row_start(next_row, cfg);
                  end
                  PH_IMAGE_END, PH_TABLE: begin
                     emit             = 1'b1;
                     state_in.stopped = 1'b1;
                     if (state_in.byte_position != cfg.data_length) begin
                        result.kind = KIND_ERROR;
                     end else begin
                        result.kind = KIND_DONE;
                     end
                  end
                  default: begin
                     state_in = cur;
                  end
               endcase
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ClearState;
      end else if (commit) begin
         state_ff <= state_in;
      end
   end
endmodule

// ===== rtl/sprite_rle_row_decoder_core.sv =====
`timescale 1ns / 1ps
// Decodes the payload of a row-wise run-length sprite, one byte per request.
// The req channel carries the payload bytes in file order; a byte with
// first_byte set restarts decoding at payload position zero. The rsp channel
// returns at most one result per byte: a pixel write with its column, row and
// palette index, a finished result, or a format error. After a finished or
// error result, bytes are ignored until one arrives with first_byte set.
// The image width, height and payload length are written over the APB port as
// registers 0 at 0x0, 1 at 0x4 and 2 at 0x8; the user must do so only while the
// block is idle, which the block itself does not enforce. A request is held in
// an input register and decoded from there into the result register, which
// offers it on the rsp channel. One request is accepted every cycle while the
// receiver keeps up. When the receiver stalls, the held result stays in place
// and one more request waits in the input register before ready falls; requests
// that give no result pass through even while a result is waiting.
// Reset clears the configuration registers and the decoding state and empties both stages.
module sprite_rle_row_decoder_core (
   input  logic                              clock,
   input  logic                              reset,
   srle_req_if.sink                          req_if,
   srle_rsp_if.source                        rsp_if,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [srle_pkg::CsrAddrWidth-1:0] paddr,
   input  logic [srle_pkg::CsrDataWidth-1:0] pwdata,
   output logic [srle_pkg::CsrDataWidth-1:0] prdata,
   output logic                              pready
);
   import srle_pkg::*;

   srle_cfg_type    cfg;
   logic            in_valid_ff;
   logic            in_valid_in;
   logic [7:0]      in_byte_ff;
   logic            in_first_ff;
   logic            out_valid_ff;
   logic            out_valid_in;
   srle_result_type out_ff;
   srle_result_type result;
   logic            emit;
   logic            out_free;
   logic            commit;
   logic            req_take;

   srle_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   srle_decoder u_decoder (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .data_byte  (in_byte_ff),
      .first_byte (in_first_ff),
      .commit     (commit),
      .emit       (emit),
      .result     (result)
   );

   assign out_free      = ~out_valid_ff | rsp_if.ready;
   assign commit        = in_valid_ff & (~emit | out_free);
   assign req_if.ready  = ~in_valid_ff | commit;
   assign req_take      = req_if.valid & req_if.ready;
   assign in_valid_in   = req_take | (in_valid_ff & ~commit);
   assign out_valid_in  = (commit & emit) | (out_valid_ff & ~rsp_if.ready);

   assign rsp_if.valid       = out_valid_ff;
   assign rsp_if.result_kind = out_ff.kind;
   assign rsp_if.pixel_x     = out_ff.pixel_x;
   assign rsp_if.pixel_y     = out_ff.pixel_y;
   assign rsp_if.pixel_color = out_ff.pixel_color;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff  <= req_if.data_byte;
         in_first_ff <= req_if.first_byte;
      end
      if (commit & emit) begin
         out_ff <= result;
      end
   end
endmodule

// ===== verif/sprite_rle_row_decoder_core_tb.sv =====
`timescale 1ns / 1ps
module sprite_rle_row_decoder_core_tb;
   import srle_pkg::*;

   localparam int CycleLimit = 400000;
   localparam int HoldOffCycles = 300;
   localparam int DrainCycles = 8;

   logic clock = 1'b0;
   logic reset;
   logic psel;
   logic penable;
   logic pwrite;
   logic [CsrAddrWidth-1:0] paddr;
   logic [CsrDataWidth-1:0] pwdata;
   logic [CsrDataWidth-1:0] prdata;
   logic pready;

   srle_req_if req_if ();
   srle_rsp_if rsp_if ();

   sprite_rle_row_decoder_core dut (
      .clock   (clock),
      .reset   (reset),
      .req_if  (req_if),
      .rsp_if  (rsp_if),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   always #6 clock = ~clock;

   logic [15:0] cfg_width = '0;
   logic [15:0] cfg_height = '0;
   logic [31:0] cfg_length = '0;

   srle_phase_type dec_phase = PH_TABLE;
   logic [31:0] dec_pos = '0;
   logic [15:0] dec_col = '0;
   logic [15:0] dec_row = '0;
   logic [7:0] dec_run = '0;
   logic dec_halted = 1'b0;

   srle_result_type pending_results[$];
   logic [7:0] image_bytes[$];

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int request_count = 0;
   int result_count = 0;
   int image_count = 0;
   int mismatch_count = 0;
   int cycle_count = 0;
   int hold_requests = 0;
   int hold_served = 0;
   int hold_left = 0;

   function automatic void clear_decoder();
      dec_phase = PH_TABLE;
      dec_pos = '0;
      dec_col = '0;
      dec_row = '0;
      dec_run = '0;
      dec_halted = 1'b0;
   endfunction

   function automatic srle_phase_type next_row_phase();
      if (dec_row >= cfg_height) begin
         return PH_IMAGE_END;
      end
      if (cfg_width == 0) begin
         return PH_ROW_END;
      end
      return PH_COUNT;
   endfunction

   function automatic void post_result(srle_kind_type kind, logic [15:0] x, logic [15:0] y,
                                       logic [7:0] color);
      srle_result_type r;
      r.kind = kind;
      r.pixel_x = x;
      r.pixel_y = y;
      r.pixel_color = color;
      pending_results.push_back(r);
      if (kind != KIND_PIXEL) begin
         dec_halted = 1'b1;
      end
   endfunction

   function automatic void decode_request(logic [7:0] b, logic first);
      logic [31:0] p;
      logic [15:0] x;
      if (first) begin
         clear_decoder();
      end
      if (dec_halted) begin
         return;
      end
      if (cfg_length == 0) begin
         post_result(KIND_DONE, 0, 0, 0);
         return;
      end
      p = dec_pos;
      if (p >= cfg_length) begin
         post_result(KIND_ERROR, 0, 0, 0);
         return;
      end
      dec_pos = p + 1;
      if (dec_phase == PH_TABLE) begin
         if ({1'b0, p} < {16'b0, cfg_height, 1'b0}) begin
            return;
         end
         dec_phase = next_row_phase();
      end
      case (dec_phase)
         PH_COUNT: begin
            if ({2'b0, p} + 34'(b) + 34'd2 >= {2'b0, cfg_length}) begin
               post_result(KIND_ERROR, 0, 0, 0);
               return;
            end
            dec_run = b;
            if (b != 0) begin
               dec_phase = PH_COLOR;
            end else begin
               dec_phase = PH_TRANS;
            end
         end
         PH_COLOR: begin
            x = dec_col;
            dec_col = dec_col + 16'd1;
            dec_run = dec_run - 8'd1;
            if (dec_run == 0) begin
               dec_phase = PH_TRANS;
            end
            post_result(KIND_PIXEL, x, dec_row, b);
         end
         PH_TRANS: begin
            dec_col = dec_col + 16'(b);
            if (dec_col < cfg_width) begin
               dec_phase = PH_COUNT;
            end else begin
               dec_phase = PH_ROW_END;
            end
         end
         PH_ROW_END: begin
            dec_row = dec_row + 16'd1;
            dec_col = '0;
            dec_phase = next_row_phase();
         end
         default: begin
            if (dec_pos != cfg_length) begin
               post_result(KIND_ERROR, 0, 0, 0);
            end else begin
               post_result(KIND_DONE, 0, 0, 0);
            end
         end
      endcase
   endfunction

   task automatic report_mismatch(string what);
      $display("%0t ns: %s", $realtime, what);
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("Timed out after %0d cycles with %0d results outstanding.", cycle_count,
                  pending_results.size());
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   always @(posedge clock) begin
      srle_result_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_results.size() == 0) begin
            report_mismatch($sformatf("unexpected result kind %0d x %0d y %0d colour %0d",
                                      rsp_if.result_kind, rsp_if.pixel_x, rsp_if.pixel_y,
                                      rsp_if.pixel_color));
         end else begin
            want = pending_results.pop_front();
            result_count++;
            if (rsp_if.result_kind !== want.kind || rsp_if.pixel_x !== want.pixel_x ||
                rsp_if.pixel_y !== want.pixel_y || rsp_if.pixel_color !== want.pixel_color) begin
               report_mismatch($sformatf(
                  "result %0d: got kind %0d (%0d,%0d) colour %0d, want kind %0d (%0d,%0d) colour %0d",
                  result_count, rsp_if.result_kind, rsp_if.pixel_x, rsp_if.pixel_y,
                  rsp_if.pixel_color, want.kind, want.pixel_x, want.pixel_y, want.pixel_color));
            end
         end
      end
   end

   // The receiver stalls at random, or for a long stretch when the stimulus asks for one.
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_if.ready = 1'b0;
         hold_left--;
      end else if (hold_requests != hold_served) begin
         hold_served++;
         hold_left = HoldOffCycles - 1;
         rsp_if.ready = 1'b0;
      end else begin
         rsp_if.ready = ($urandom_range(99) >= recv_idle_pct);
      end
   end

   task automatic csr_write(srle_reg_type idx, logic [31:0] value);
      psel = 1'b1;
      penable = 1'b0;
      pwrite = 1'b1;
      paddr = {idx, 2'b00};
      pwdata = value;
      @(negedge clock);
      penable = 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      case (idx)
         REG_IMAGE_WIDTH: cfg_width = value[15:0];
         REG_IMAGE_HEIGHT: cfg_height = value[15:0];
         default: cfg_length = value;
      endcase
      @(negedge clock);
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
   endtask

   task automatic settle();
      req_if.valid = 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (DrainCycles) @(negedge clock);
   endtask

   task automatic program_image(logic [15:0] w, logic [15:0] h, logic [31:0] len);
      settle();
      csr_write(REG_IMAGE_WIDTH, {16'b0, w});
      csr_write(REG_IMAGE_HEIGHT, {16'b0, h});
      csr_write(REG_DATA_LENGTH, len);
   endtask

   task automatic send_byte(logic [7:0] b, logic first);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid = 1'b0;
         @(negedge clock);
      end
      req_if.valid = 1'b1;
      req_if.data_byte = b;
      req_if.first_byte = first;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      decode_request(b, first);
      request_count++;
      @(negedge clock);
   endtask

   task automatic send_stream(int hold_at, bit noisy);
      foreach (image_bytes[i]) begin
         if (i == hold_at) begin
            hold_requests++;
         end
         send_byte(image_bytes[i], (i == 0) || (noisy && $urandom_range(7) == 0));
      end
      image_count++;
   endtask

   function automatic logic [7:0] pick_terminator();
      if ($urandom_range(7) == 0) begin
         return 8'($urandom);
      end
      return 8'hFF;
   endfunction

   function automatic void build_image(int w, int h, int max_run);
      int col;
      int rem;
      int c;
      int t;
      image_bytes.delete();
      repeat (2 * h) image_bytes.push_back(8'($urandom));
      repeat (h) begin
         col = 0;
         while (col < w) begin
            rem = w - col;
            c = $urandom_range(0, (rem < max_run) ? rem : max_run);
            if ($urandom_range(15) == 0) begin
               c = (rem + 3 > 255) ? 255 : rem + $urandom_range(1, 3);
            end
            image_bytes.push_back(8'(c));
            repeat (c) image_bytes.push_back(8'($urandom));
            col += c;
            rem = w - col;
            if (rem <= 0) begin
               t = $urandom_range(0, 3);
            end else begin
               t = $urandom_range((c == 0) ? 1 : 0, (rem < 255) ? rem : 255);
            end
            image_bytes.push_back(8'(t));
            col += t;
         end
         image_bytes.push_back(pick_terminator());
      end
      image_bytes.push_back(pick_terminator());
   endfunction

   task automatic test_zero_length();
      program_image(16'd0, 16'd0, 32'd0);
      send_byte(8'h00, 1'b1);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hA5, 1'b1);
   endtask

   task automatic test_empty_images();
      program_image(16'd0, 16'd0, 32'd1);
      image_bytes = {8'hFF};
      send_stream(-1, 1'b0);
      build_image(0, 2, 8);
      program_image(16'd0, 16'd2, 32'(image_bytes.size()));
      send_stream(-1, 1'b0);
   endtask

   task automatic test_past_length();
      program_image(16'd3, 16'hFFFF, 32'd4);
      image_bytes.delete();
      repeat (6) image_bytes.push_back(8'($urandom));
      send_stream(-1, 1'b0);
   endtask

   task automatic test_run_overrun();
      program_image(16'd10, 16'd1, 32'd8);
      image_bytes = {8'h12, 8'h34, 8'd200, 8'h55};
      send_stream(-1, 1'b0);
   endtask

   task automatic test_final_mismatch();
      build_image(2, 1, 2);
      program_image(16'd2, 16'd1, 32'(image_bytes.size() + 1));
      send_stream(-1, 1'b0);
   endtask

   task automatic test_pixels_past_width();
      image_bytes = {8'h00, 8'h00, 8'd4, 8'h00, 8'h7F, 8'h80, 8'hFF, 8'd0, 8'hFF, 8'hFF};
      program_image(16'd2, 16'd1, 32'(image_bytes.size()));
      send_stream(-1, 1'b0);
   endtask

   // Transparent steps bring the column to the top of its range, and the row then wraps it
   // either while writing pixels or while adding a transparent count.
   task automatic test_column_wrap();
      int col;
      int t;
      program_image(16'hFFFF, 16'd1, 32'hFFFF_FFFF);
      image_bytes.delete();
      image_bytes.push_back(8'($urandom));
      image_bytes.push_back(8'($urandom));
      col = 0;
      while (col < 65534) begin
         t = (65534 - col < 255) ? 65534 - col : 255;
         image_bytes.push_back(8'd0);
         image_bytes.push_back(8'(t));
         col += t;
      end
      if ($urandom_range(1) == 0) begin
         image_bytes.push_back(8'd3);
         repeat (3) image_bytes.push_back(8'($urandom));
      end else begin
         image_bytes.push_back(8'd1);
         image_bytes.push_back(8'($urandom));
         image_bytes.push_back(8'($urandom_range(2, 255)));
         image_bytes.push_back(8'd1);
         image_bytes.push_back(8'($urandom));
      end
      send_stream(-1, 1'b0);
   endtask

   task automatic test_random_images(int n);
      int target;
      int sel;
      int w;
      int h;
      int len;
      int cut;
      bit noisy;
      target = request_count + n;
      while (request_count < target) begin
         sel = $urandom_range(99);
         noisy = 1'b0;
         if ($urandom_range(15) == 0) begin
            w = $urandom_range(256, 400);
            h = $urandom_range(0, 1);
         end else begin
            w = $urandom_range(0, 24);
            h = $urandom_range(0, 5);
         end
         build_image(w, h, ($urandom_range(3) == 0) ? 255 : 8);
         len = image_bytes.size();
         if (sel < 70) begin
            if ($urandom_range(3) == 0) begin
               repeat ($urandom_range(1, 3)) image_bytes.push_back(8'($urandom));
            end
         end else if (sel < 82) begin
            if ($urandom_range(1) == 0 || len < 2) begin
               len += $urandom_range(1, 3);
            end else begin
               len -= $urandom_range(1, (len > 3) ? 3 : len - 1);
            end
         end else if (sel < 92) begin
            if (image_bytes.size() > 1) begin
               cut = $urandom_range(1, image_bytes.size() - 1);
               while (image_bytes.size() > cut) void'(image_bytes.pop_back());
            end
         end else begin
            w = $urandom_range(0, 8);
            h = $urandom_range(0, 3);
            len = $urandom_range(0, 40);
            image_bytes.delete();
            repeat ($urandom_range(1, 30)) image_bytes.push_back(8'($urandom));
            noisy = 1'b1;
         end
         program_image(16'(w), 16'(h), 32'(len));
         send_stream(-1, noisy);
      end
   endtask

   task automatic test_receiver_hold_off();
      build_image(30, 2, 30);
      program_image(16'd30, 16'd2, 32'(image_bytes.size()));
      send_stream(20, 1'b0);
   endtask

   initial begin
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.data_byte = '0;
      req_if.first_byte = 1'b0;
      rsp_if.ready = 1'b0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_idle_pct = 29;
      recv_idle_pct = 78;
      test_zero_length();
      test_empty_images();
      test_past_length();
      test_run_overrun();
      test_final_mismatch();
      test_pixels_past_width();
      test_column_wrap();
      test_random_images(60);

      send_idle_pct = 78;
      recv_idle_pct = 29;
      test_random_images(60);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_receiver_hold_off();
      test_random_images(50);

      settle();
      $display("Sent %0d requests in %0d images and checked %0d results.", request_count,
               image_count, result_count);
      $display("Covered zero length, early end, run overrun, length mismatch, column wrap, %s",
               "noise and a long receiver hold-off.");
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("%0d mismatches.", mismatch_count);
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
